@@ rtl/core/cic_pkg.sv @@
// Shared types, codes and helper functions for the cascaded interrupt controller.
`timescale 1ns / 1ps

package cic_pkg;

    // Item kinds
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RAISE = 2'd2;
    localparam logic [1:0] FUNC_LOWER = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_ACC = 2'd1;
    localparam logic [1:0] STATUS_BAD_CMD = 2'd2;

    // Even-port read selection
    localparam logic [1:0] SEL_IRR   = 2'd0;
    localparam logic [1:0] SEL_ISR   = 2'd1;
    localparam logic [1:0] SEL_INDEX = 2'd2;

    // Port bases and command bytes
    localparam logic [15:0] PRI_BASE    = 16'h0020;
    localparam logic [15:0] SEC_BASE    = 16'h00a0;
    localparam logic [7:0]  CMD_SEL_IRR = 8'h0a;
    localparam logic [7:0]  CMD_SEL_ISR = 8'h0b;
    localparam logic [7:0]  CMD_SEL_IDX = 8'h0c;
    localparam logic [3:0]  CMD_INIT_HI = 4'h1;
    localparam logic [4:0]  CMD_NSEOI_HI = 5'b00100;
    localparam logic [4:0]  CMD_SEOI_HI  = 5'b01100;
    localparam logic [7:0]  INDEX_FLAG  = 8'h80;
    localparam logic [7:0]  MASK_RESET  = 8'hff;
    localparam int unsigned CASCADE_LINE = 2;

    typedef logic [7:0] bits8_t;

    // Keep only the lowest set bit
    function automatic bits8_t lowest_one_hot(input bits8_t v);
        return v & (~v + 8'd1);
    endfunction

    // 0x80 plus the lowest set bit index, or zero when nothing is set
    function automatic bits8_t lowest_index(input bits8_t v);
        bits8_t r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r = INDEX_FLAG | bits8_t'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cascaded_interrupt_controller_unit.sv @@
// Top level of the cascaded interrupt controller: request register, update logic, result register.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready  | func, port_address, access_size,
//           |           |                    | write_data, irq_line
//  m_       | out       | m_valid / m_ready  | read_data, status, cpu_irq
//
//  Each request passes through the input register and then the result
//  register. A new request is accepted every cycle while the result register is not stalled.
//  Controller state updates as a request moves from the input to the result register.
//  Reset (aresetn low, synchronous) clears both stages and restores the state.
//  A stalled result register holds the input register, which then holds s_ready low.
`timescale 1ns / 1ps

module cascaded_interrupt_controller_unit
    import cic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_port_address,
    input  logic [3:0]  s_access_size,
    input  logic [7:0]  s_write_data,
    input  logic [3:0]  s_irq_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [1:0]  m_status,
    output logic        m_cpu_irq
);

    // Input register
    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [15:0] port_reg;
    logic [3:0]  size_reg;
    logic [7:0]  data_reg;
    logic [3:0]  line_reg;

    // Result register
    logic        out_valid_reg;
    logic [7:0]  rd_reg, rd_next;
    logic [1:0]  status_reg, status_next;
    logic        irq_reg, irq_next;

    // Controller state, index 0 primary, 1 secondary
    bits8_t      req_reg  [2];
    bits8_t      mask_reg [2];
    bits8_t      svc_reg  [2];
    logic [1:0]  sel_reg  [2];
    logic [1:0]  skip_reg [2];
    bits8_t      req_next  [2];
    bits8_t      mask_next [2];
    bits8_t      svc_next  [2];
    logic [1:0]  sel_next  [2];
    logic [1:0]  skip_next [2];

    logic        advance;
    logic        out_free;

    // Work signals of the update logic
    bits8_t      req_m  [2];
    bits8_t      mask_m [2];
    bits8_t      svc_m  [2];
    logic        do_recalc;
    logic        bus_ok;
    logic        ch;
    logic        casc;
    bits8_t      req0_c;
    bits8_t      line_bit;
    bits8_t      eoi_bit;

    function automatic logic s_size_ok(input logic [3:0] sz);
        return sz == 4'd1;
    endfunction

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid     = out_valid_reg;
    assign m_read_data = rd_reg;
    assign m_status    = status_reg;
    assign m_cpu_irq   = irq_reg;

    // Decode and apply one request
    always_comb begin
        req_m     = req_reg;
        mask_m    = mask_reg;
        svc_m     = svc_reg;
        sel_next  = sel_reg;
        skip_next = skip_reg;
        do_recalc = 1'b0;
        rd_next     = '0;
        status_next = STATUS_OK;
        bus_ok   = (s_size_ok(size_reg)) &&
                   ((port_reg & 16'hfffe) == PRI_BASE || (port_reg & 16'hfffe) == SEC_BASE);
        ch       = port_reg[7];
        line_bit = bits8_t'(8'd1 << line_reg[2:0]);
        eoi_bit  = bits8_t'(8'd1 << data_reg[2:0]);

        unique case (func_reg)
            FUNC_RAISE: begin
                req_m[line_reg[3]] = req_reg[line_reg[3]] | line_bit;
                do_recalc = 1'b1;
            end
            FUNC_LOWER: begin
                req_m[line_reg[3]] = req_reg[line_reg[3]] & ~line_bit;
                do_recalc = 1'b1;
            end
            FUNC_READ: begin
                if (!bus_ok) begin
                    status_next = STATUS_BAD_ACC;
                end else if (port_reg[0]) begin
                    rd_next = mask_reg[ch];
                end else begin
                    unique case (sel_reg[ch])
                        SEL_IRR:   rd_next = req_reg[ch];
                        SEL_ISR:   rd_next = svc_reg[ch];
                        default:   rd_next = lowest_index(req_reg[ch]);
                    endcase
                end
            end
            default: begin
                if (!bus_ok) begin
                    status_next = STATUS_BAD_ACC;
                end else if (port_reg[0]) begin
                    if (skip_reg[ch] != 2'd0) begin
                        skip_next[ch] = skip_reg[ch] - 2'd1;
                    end else begin
                        mask_m[ch] = data_reg;
                        do_recalc = 1'b1;
                    end
                end else begin
                    priority if (data_reg == CMD_SEL_IRR) begin
                        sel_next[ch] = SEL_IRR;
                    end else if (data_reg == CMD_SEL_ISR) begin
                        sel_next[ch] = SEL_ISR;
                    end else if (data_reg == CMD_SEL_IDX) begin
                        sel_next[ch] = SEL_INDEX;
                    end else if (data_reg[7:4] == CMD_INIT_HI) begin
                        skip_next[ch] = {1'b1, data_reg[0]};
                    end else if (data_reg[7:3] == CMD_NSEOI_HI) begin
                        req_m[ch] = req_reg[ch] & ~svc_reg[ch];
                        svc_m[ch] = '0;
                        do_recalc = 1'b1;
                    end else if (data_reg[7:3] == CMD_SEOI_HI) begin
                        req_m[ch] = req_reg[ch] & ~eoi_bit;
                        svc_m[ch] = svc_reg[ch] & ~eoi_bit;
                        do_recalc = 1'b1;
                    end else begin
                        status_next = STATUS_BAD_CMD;
                    end
                end
            end
        endcase

        // Recompute cascade, in-service values and the processor line
        casc   = |(req_m[1] & ~mask_m[1]);
        req0_c = req_m[0];
        req0_c[CASCADE_LINE] = casc;
        mask_next = mask_m;
        if (do_recalc) begin
            req_next[0] = req0_c;
            req_next[1] = req_m[1];
            svc_next[0] = lowest_one_hot(req0_c & ~mask_m[0]);
            svc_next[1] = lowest_one_hot(req_m[1] & ~mask_m[1]);
            irq_next    = |lowest_one_hot(req0_c & ~mask_m[0]);
        end else begin
            req_next = req_m;
            svc_next = svc_m;
            irq_next = irq_reg;
        end
    end

    // Capture requests into the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            port_reg <= s_port_address;
            size_reg <= s_access_size;
            data_reg <= s_write_data;
            line_reg <= s_irq_line;
        end
    end

    // Commit state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            irq_reg       <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                req_reg[c]  <= '0;
                mask_reg[c] <= MASK_RESET;
                svc_reg[c]  <= '0;
                sel_reg[c]  <= SEL_INDEX;
                skip_reg[c] <= '0;
            end
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                irq_reg  <= irq_next;
                req_reg  <= req_next;
                mask_reg <= mask_next;
                svc_reg  <= svc_next;
                sel_reg  <= sel_next;
                skip_reg <= skip_next;
            end
        end
        if (advance) begin
            rd_reg     <= rd_next;
            status_reg <= status_next;
        end
    end

    // Processor line tracks the primary in-service value
    assert property (@(posedge aclk) disable iff (!aresetn)
        irq_reg == (svc_reg[0] != 8'd0))
        else $error("irq line disagrees with primary in-service value");

    // In-service values are one-hot or zero and never masked
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(svc_reg[0]) && $onehot0(svc_reg[1]))
        else $error("in-service value not one-hot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((svc_reg[0] & mask_reg[0]) == 8'd0) && ((svc_reg[1] & mask_reg[1]) == 8'd0))
        else $error("masked line in service");

    // Primary cascade line mirrors the secondary's unmasked requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_reg[0][CASCADE_LINE] == (|(req_reg[1] & ~mask_reg[1])))
        else $error("cascade line out of step with secondary");

    // A stalled result holds both stages and the waiting request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |=>
            in_valid_reg && out_valid_reg && $stable(port_reg) && $stable(data_reg))
        else $error("input stage lost a request under stall");

endmodule

@@ dv/cic_result_checker.sv @@
// Result checker for the cascaded interrupt controller: predicts each result and compares it.
`timescale 1ns / 1ps

module cic_result_checker
    import cic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_port_address,
    input  logic [3:0]  s_access_size,
    input  logic [7:0]  s_write_data,
    input  logic [3:0]  s_irq_line,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_read_data,
    input  logic [1:0]  m_status,
    input  logic        m_cpu_irq,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       cpu_irq;
    } pic_result_t;

    // Shadow copy of both controllers (index 0 primary, 1 secondary)
    logic [7:0] irr [2];
    logic [7:0] imr [2];
    logic [7:0] isr [2];
    logic [1:0] rd_sel [2];
    logic [1:0] init_skip [2];
    logic       irq_out;

    pic_result_t result_q [$];

    function automatic void clear_controllers();
        for (int c = 0; c < 2; c++) begin
            irr[c]       = '0;
            imr[c]       = MASK_RESET;
            isr[c]       = '0;
            rd_sel[c]    = SEL_INDEX;
            init_skip[c] = '0;
        end
        irq_out = 1'b0;
    endfunction

    // Fold the secondary into primary line 2, then grant the lowest unmasked request
    function automatic void resolve_priority();
        logic [7:0] pend;
        irr[0][CASCADE_LINE] = |(irr[1] & ~imr[1]);
        for (int c = 0; c < 2; c++) begin
            pend   = irr[c] & ~imr[c];
            isr[c] = '0;
            for (int i = 7; i >= 0; i--) begin
                if (pend[i]) begin
                    isr[c] = 8'd1 << i;
                end
            end
        end
        irq_out = |isr[0];
    endfunction

    // Apply one request to the shadow state and return the result it should produce
    function automatic pic_result_t predict_result(
        input logic [1:0]  func,
        input logic [15:0] port,
        input logic [3:0]  size,
        input logic [7:0]  data,
        input logic [3:0]  line
    );
        pic_result_t r;
        int          ch;
        logic [15:0] base;
        r    = '0;
        base = {port[15:1], 1'b0};
        if (func == FUNC_RAISE || func == FUNC_LOWER) begin
            ch = line[3];
            irr[ch][line[2:0]] = (func == FUNC_RAISE);
            resolve_priority();
        end else if (size != 4'd1 || (base != PRI_BASE && base != SEC_BASE)) begin
            r.status = STATUS_BAD_ACC;
        end else begin
            ch = (base == SEC_BASE);
            if (func == FUNC_READ) begin
                if (port[0]) begin
                    r.read_data = imr[ch];
                end else begin
                    case (rd_sel[ch])
                        SEL_IRR: r.read_data = irr[ch];
                        SEL_ISR: r.read_data = isr[ch];
                        default: begin
                            // lowest pending index, mask ignored
                            for (int i = 7; i >= 0; i--) begin
                                if (irr[ch][i]) begin
                                    r.read_data = INDEX_FLAG | 8'(i);
                                end
                            end
                        end
                    endcase
                end
            end else if (port[0]) begin
                // mask write, unless an init sequence still swallows it
                if (init_skip[ch] != 2'd0) begin
                    init_skip[ch] = init_skip[ch] - 2'd1;
                end else begin
                    imr[ch] = data;
                    resolve_priority();
                end
            end else if (data == CMD_SEL_IRR) begin
                rd_sel[ch] = SEL_IRR;
            end else if (data == CMD_SEL_ISR) begin
                rd_sel[ch] = SEL_ISR;
            end else if (data == CMD_SEL_IDX) begin
                rd_sel[ch] = SEL_INDEX;
            end else if (data[7:4] == CMD_INIT_HI) begin
                init_skip[ch] = 2'd2 + {1'b0, data[0]};
            end else if (data[7:3] == CMD_NSEOI_HI) begin
                irr[ch] = irr[ch] & ~isr[ch];
                isr[ch] = '0;
                resolve_priority();
            end else if (data[7:3] == CMD_SEOI_HI) begin
                irr[ch][data[2:0]] = 1'b0;
                isr[ch][data[2:0]] = 1'b0;
                resolve_priority();
            end else begin
                r.status = STATUS_BAD_CMD;
            end
        end
        r.cpu_irq = irq_out;
        return r;
    endfunction

    // Compare outgoing results, then record the expectation for an incoming request
    always @(posedge aclk) begin : watch
        pic_result_t want;
        logic        bad;
        if (!aresetn) begin
            clear_controllers();
            result_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result read_data=%h status=%0d cpu_irq=%b",
                             $realtime, m_read_data, m_status, m_cpu_irq);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    bad  = 1'b0;
                    if (m_read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $realtime, want.read_data, m_read_data);
                        bad = 1'b1;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, m_status);
                        bad = 1'b1;
                    end
                    if (m_cpu_irq !== want.cpu_irq) begin
                        $display("%0t: cpu_irq expected %b actual %b",
                                 $realtime, want.cpu_irq, m_cpu_irq);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                result_q.push_back(predict_result(s_func, s_port_address, s_access_size,
                                                  s_write_data, s_irq_line));
            end
        end
        pending = result_q.size();
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the cascaded interrupt controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import cic_pkg::*;
();

    localparam int RANDOM_ITEMS    = 1900;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int DRAIN_CYCLES    = 4;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic [1:0]  s_func         = FUNC_READ;
    logic [15:0] s_port_address = '0;
    logic [3:0]  s_access_size  = '0;
    logic [7:0]  s_write_data   = '0;
    logic [3:0]  s_irq_line     = '0;
    logic        m_ready        = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_read_data;
    logic [1:0]  m_status;
    logic        m_cpu_irq;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;

    cascaded_interrupt_controller_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_port_address (s_port_address),
        .s_access_size  (s_access_size),
        .s_write_data   (s_write_data),
        .s_irq_line     (s_irq_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_status       (m_status),
        .m_cpu_irq      (m_cpu_irq)
    );

    cic_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_port_address (s_port_address),
        .s_access_size  (s_access_size),
        .s_write_data   (s_write_data),
        .s_irq_line     (s_irq_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_status       (m_status),
        .m_cpu_irq      (m_cpu_irq),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request, with a random gap at the start of each burst, and wait for it to go in
    task automatic send_request(
        input logic [1:0]  func,
        input logic [15:0] port,
        input logic [3:0]  size,
        input logic [7:0]  data,
        input logic [3:0]  line
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_func         <= func;
        s_port_address <= port;
        s_access_size  <= size;
        s_write_data   <= data;
        s_irq_line     <= line;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Mostly well-formed traffic, with some noise and bad accesses
    task automatic send_random_request();
        int          kind;
        logic [1:0]  func;
        logic [15:0] port;
        logic [3:0]  size;
        logic [7:0]  data;
        logic [3:0]  line;
        kind    = $urandom_range(0, 99);
        func    = FUNC_READ;
        port    = $urandom_range(0, 1) ? PRI_BASE : SEC_BASE;
        port[0] = $urandom_range(0, 1);
        size    = 4'd1;
        data    = 8'($urandom_range(0, 255));
        line    = 4'($urandom_range(0, 15));
        if (kind < 30) begin
            // line events ignore the bus fields, so scramble them
            func = ($urandom_range(0, 2) != 0) ? FUNC_RAISE : FUNC_LOWER;
            port = 16'($urandom_range(0, 65535));
            size = 4'($urandom_range(0, 8));
        end else if (kind < 55) begin
            func = FUNC_READ;
        end else if (kind < 70) begin
            func    = FUNC_WRITE;
            port[0] = 1'b1;
        end else if (kind < 88) begin
            func    = FUNC_WRITE;
            port[0] = 1'b0;
            case ($urandom_range(0, 5))
                0: data = CMD_SEL_IRR;
                1: data = CMD_SEL_ISR;
                2: data = CMD_SEL_IDX;
                3: data = {CMD_INIT_HI, 4'($urandom_range(0, 15))};
                4: data = {CMD_NSEOI_HI, 3'($urandom_range(0, 7))};
                default: data = {CMD_SEOI_HI, 3'($urandom_range(0, 7))};
            endcase
        end else if (kind < 94) begin
            func    = FUNC_WRITE;
            port[0] = 1'b0;
        end else begin
            func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
            port = 16'($urandom_range(0, 65535));
            size = 4'($urandom_range(0, 8));
        end
        send_request(func, port, size, data, line);
    endtask

    // Request stimulus and verdict
    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, bad sizes and addresses
        send_request(FUNC_READ,  PRI_BASE,         4'd1, 8'h00, 4'd0);
        send_request(FUNC_READ,  PRI_BASE | 16'd1, 4'd1, 8'h00, 4'd0);
        send_request(FUNC_READ,  PRI_BASE,         4'd0, 8'h00, 4'd0);
        send_request(FUNC_WRITE, SEC_BASE,         4'd8, 8'hff, 4'd0);
        send_request(FUNC_READ,  16'hffff,         4'd1, 8'h00, 4'd0);
        send_request(FUNC_WRITE, 16'h0000,         4'd1, CMD_SEL_IRR, 4'd0);

        // masked raise, then unmask; cascade through the secondary
        send_request(FUNC_RAISE, 16'hffff,         4'd8, 8'hff, 4'd0);
        send_request(FUNC_WRITE, PRI_BASE | 16'd1, 4'd1, 8'h00, 4'd0);
        send_request(FUNC_RAISE, 16'h0000,         4'd0, 8'h00, 4'd15);
        send_request(FUNC_WRITE, SEC_BASE | 16'd1, 4'd1, 8'h7f, 4'd0);
        send_request(FUNC_WRITE, SEC_BASE | 16'd1, 4'd1, 8'h00, 4'd0);

        // the cascade line itself cannot be driven
        send_request(FUNC_RAISE, 16'h0000, 4'd1, 8'h00, 4'd2);
        send_request(FUNC_LOWER, 16'h0000, 4'd1, 8'h00, 4'd2);

        // read selection and both kinds of end of interrupt
        send_request(FUNC_WRITE, PRI_BASE, 4'd1, CMD_SEL_IRR, 4'd0);
        send_request(FUNC_READ,  PRI_BASE, 4'd1, 8'h00, 4'd0);
        send_request(FUNC_WRITE, SEC_BASE, 4'd1, CMD_SEL_ISR, 4'd0);
        send_request(FUNC_READ,  SEC_BASE, 4'd1, 8'h00, 4'd0);
        send_request(FUNC_WRITE, PRI_BASE, 4'd1, {CMD_NSEOI_HI, 3'd7}, 4'd0);
        send_request(FUNC_WRITE, SEC_BASE, 4'd1, {CMD_SEOI_HI, 3'd7}, 4'd0);
        send_request(FUNC_WRITE, PRI_BASE, 4'd1, {CMD_SEOI_HI, 3'd0}, 4'd0);

        // init with three skipped mask writes, the fourth one lands
        send_request(FUNC_WRITE, PRI_BASE, 4'd1, {CMD_INIT_HI, 4'hf}, 4'd0);
        for (int k = 0; k < 4; k++) begin
            send_request(FUNC_WRITE, PRI_BASE | 16'd1, 4'd1, 8'(8'h55 * k), 4'd0);
        end

        // undefined command bytes
        send_request(FUNC_WRITE, PRI_BASE, 4'd1, 8'hff, 4'd0);
        send_request(FUNC_WRITE, SEC_BASE, 4'd1, 8'h00, 4'd0);

        repeat (RANDOM_ITEMS) send_random_request();
        s_valid <= 1'b0;

        // drain outstanding results, then allow for stray ones
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: stall patterns, plus one long hold-off while requests keep coming
    initial begin : result_drain
        int  mode;
        int  span;
        bit  held_off;
        held_off = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (int step = 0; step < span; step++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (step % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

endmodule
